[src/blpi_pkg.sv]
// ----------------------------------------------------------------------------
// blpi_pkg
// Shared widths, action codes and cell control word for the bounded list.
// ----------------------------------------------------------------------------
package blpi_pkg;

   localparam int unsigned DEPTH_DEF     = 64;
   localparam int unsigned ITEM_BITS_DEF = 32;

   localparam int unsigned ACTION_W   = 3;
   localparam int unsigned REQ_ITEM_W = 32;
   localparam int unsigned POSITION_W = 7;
   localparam int unsigned LENGTH_W   = 7;
   localparam int unsigned REMOVED_W  = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND    = 3'd0,
      ACT_PUSH      = 3'd1,
      ACT_INSERT    = 3'd2,
      ACT_POP_FRONT = 3'd3,
      ACT_POP_BACK  = 3'd4
   } action_type;

   typedef struct packed {
      logic ins;
      logic pull;
      logic tap;
   } cell_ctl_type;

endpackage

[src/blpi_cell.sv]
// ----------------------------------------------------------------------------
// blpi_cell
// One list slot: holds a word, takes it from a neighbor or the request.
// ----------------------------------------------------------------------------
module blpi_cell
   import blpi_pkg::*;
#(
   parameter int unsigned INDEX     = 0,
   parameter int unsigned ITEM_BITS = ITEM_BITS_DEF,
   parameter int unsigned CNT_W     = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctl_type         ctl,
   input  logic [CNT_W-1:0]     where,
   input  logic [ITEM_BITS-1:0] item,
   input  logic [ITEM_BITS-1:0] left_word,
   input  logic [ITEM_BITS-1:0] right_word,
   output logic [ITEM_BITS-1:0] word,
   output logic [ITEM_BITS-1:0] tap_word
);

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic [ITEM_BITS-1:0] word_ff;
   logic [ITEM_BITS-1:0] word_in;
   logic                 tap_ff;
   logic                 tap_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.ins && (IDX > where)) begin
         word_in = left_word;
      end else if (ctl.ins && (IDX == where)) begin
         word_in = item;
      end else if (ctl.pull) begin
         word_in = right_word;
      end
   end

   assign tap_in = ctl.tap && (IDX == where);

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= 1'b0;
      end else begin
         tap_ff <= tap_in;
      end
   end

   assign word     = word_ff;
   assign tap_word = tap_ff ? word_ff : '0;

endmodule

[src/blpi_pick.sv]
// ----------------------------------------------------------------------------
// blpi_pick
// Merge the tapped cell words; at most one cell taps at a time.
// ----------------------------------------------------------------------------
module blpi_pick
   import blpi_pkg::*;
#(
   parameter int unsigned DEPTH     = DEPTH_DEF,
   parameter int unsigned ITEM_BITS = ITEM_BITS_DEF
) (
   input  logic [DEPTH-1:0][ITEM_BITS-1:0] taps,
   output logic [ITEM_BITS-1:0]            word
);

   always_comb begin
      word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         word = word | taps[i];
      end
   end

endmodule

[src/bounded_list_with_positional_insert_top.sv]
// An accepted word sets stage_ff, and stage_ff then sets strobe_ff, which drives rsp_strobe.
// busy is high for the cycle after accept, so no new word is taken until busy drops.
// The cell row shifts all later elements in the accept cycle; a back pop reads
// its element through the tap merge in the following cycle.
// The receiver cannot stall: rsp_strobe is high for exactly one cycle.
// Reset (synchronous) empties the list; cell contents stay undefined.
// ----------------------------------------------------------------------------
// bounded_list_with_positional_insert_top
// Ordered list with append, push, positional insert and pops at both ends.
// ----------------------------------------------------------------------------
module bounded_list_with_positional_insert_top
   import blpi_pkg::*;
#(
   parameter int unsigned DEPTH     = DEPTH_DEF,
   parameter int unsigned ITEM_BITS = ITEM_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [REQ_ITEM_W-1:0] req_item,
   input  logic [POSITION_W-1:0] req_position,
   output logic                  rsp_strobe,
   output logic                  rsp_status,
   output logic [REMOVED_W-1:0]  rsp_removed_item,
   output logic [LENGTH_W-1:0]   rsp_length
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 stage_ff;
   logic                 strobe_ff;
   logic                 fail_ff;
   logic [ITEM_BITS-1:0] hold_ff;
   logic [ITEM_BITS-1:0] hold_in;
   logic                 rsp_status_ff;
   logic [REMOVED_W-1:0] rsp_removed_ff;
   logic [LENGTH_W-1:0]  rsp_length_ff;

   logic                 accept;
   logic                 full;
   logic                 empty;
   logic                 pos_ok;
   logic                 ok;
   logic                 ins;
   logic                 pull;
   logic                 tap;
   logic                 front;
   logic [CNT_W-1:0]     where;
   cell_ctl_type         ctl;
   logic [ITEM_BITS-1:0] item_w;
   logic [ITEM_BITS-1:0] picked;

   logic [DEPTH-1:0][ITEM_BITS-1:0] words;
   logic [DEPTH-1:0][ITEM_BITS-1:0] taps;

   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign pos_ok = (CMP_W'(req_position) <= CMP_W'(count_ff));
   assign item_w = ITEM_BITS'(req_item);

   always_comb begin
      ok    = 1'b0;
      ins   = 1'b0;
      pull  = 1'b0;
      tap   = 1'b0;
      front = 1'b0;
      where = count_ff;
      unique case (req_action)
         ACT_APPEND: begin
            ok    = !full;
            ins   = 1'b1;
            where = count_ff;
         end
         ACT_PUSH: begin
            ok    = !full;
            ins   = 1'b1;
            where = '0;
         end
         ACT_INSERT: begin
            ok    = !full && pos_ok;
            ins   = 1'b1;
            where = CNT_W'(req_position);
         end
         ACT_POP_FRONT: begin
            ok    = !empty;
            pull  = 1'b1;
            front = 1'b1;
         end
         ACT_POP_BACK: begin
            ok    = !empty;
            tap   = 1'b1;
            where = count_ff - CNT_W'(1);
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   assign ctl.ins  = accept && ok && ins;
   assign ctl.pull = accept && ok && pull;
   assign ctl.tap  = accept && ok && tap;

   always_comb begin
      count_in = count_ff;
      if (ctl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pull || ctl.tap) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign hold_in = accept ? ((ok && front) ? words[0] : '0) : hold_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ITEM_BITS-1:0] left_word;
      logic [ITEM_BITS-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = item_w;
      end else begin : g_mid_left
         assign left_word = words[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_word = words[i];
      end else begin : g_mid_right
         assign right_word = words[i+1];
      end

      blpi_cell #(
         .INDEX     (i),
         .ITEM_BITS (ITEM_BITS),
         .CNT_W     (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .where      (where),
         .item       (item_w),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (words[i]),
         .tap_word   (taps[i])
      );
   end

   blpi_pick #(
      .DEPTH     (DEPTH),
      .ITEM_BITS (ITEM_BITS)
   ) u_pick (
      .taps (taps),
      .word (picked)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         stage_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         stage_ff  <= accept;
         strobe_ff <= stage_ff;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (accept) begin
         fail_ff <= !ok;
      end
      if (stage_ff) begin
         rsp_status_ff  <= fail_ff;
         rsp_removed_ff <= REMOVED_W'(hold_ff | picked);
         rsp_length_ff  <= LENGTH_W'(count_ff);
      end
   end

   assign busy             = stage_ff;
   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_removed_item = rsp_removed_ff;
   assign rsp_length       = rsp_length_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accept");

   a_busy_strobe: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe)
      else $error("result strobe missing");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> (rsp_removed_item == '0))
      else $error("failed word returned an element");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("list length beyond depth");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives list requests through the command port and scores every response.
// A shadow copy of the list predicts status, popped element and length per
// word; a short table covers empty, full-range and bad-position cases, then
// grow/shrink/mixed random phases fill the list to capacity and drain it.
// ----------------------------------------------------------------------------
module tb_top
   import blpi_pkg::*;
();

   localparam int LIST_DEPTH     = DEPTH_DEF;
   localparam int RANDOM_WORDS   = 850;
   localparam int NUM_DIRECTED   = 22;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 8;

   localparam logic [ACTION_W-1:0] ACT_RSVD_5 = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_RSVD_6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_RSVD_7 = 3'd7;

   typedef struct packed {
      logic                 status;
      logic [REMOVED_W-1:0] removed;
      logic [LENGTH_W-1:0]  length;
   } list_result_type;

   typedef struct packed {
      logic [ACTION_W-1:0]   action;
      logic [REQ_ITEM_W-1:0] item;
      logic [POSITION_W-1:0] position;
      logic                  typed;
      list_result_type       result;
   } list_row_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [ACTION_W-1:0]   req_action;
   logic [REQ_ITEM_W-1:0] req_item;
   logic [POSITION_W-1:0] req_position;
   logic                  rsp_strobe;
   logic                  rsp_status;
   logic [REMOVED_W-1:0]  rsp_removed_item;
   logic [LENGTH_W-1:0]   rsp_length;

   logic [REQ_ITEM_W-1:0] shadow_cells [LIST_DEPTH];
   int                    shadow_len;
   list_result_type       expected_results [$];
   int                    mismatch_count = 0;
   int                    stall_cycles;

   // typed rows: failures on the empty list, the first extreme words and a bad insert position
   list_row_type directed_rows [NUM_DIRECTED] = '{
      '{ACT_POP_FRONT, 32'h0000_0000, 7'd0,   1'b1, '{1'b1, 32'h0, 7'd0}},
      '{ACT_POP_BACK,  32'h0000_0000, 7'd0,   1'b1, '{1'b1, 32'h0, 7'd0}},
      '{ACT_INSERT,    32'h1234_5678, 7'd1,   1'b1, '{1'b1, 32'h0, 7'd0}},
      '{ACT_INSERT,    32'hFFFF_FFFF, 7'd127, 1'b1, '{1'b1, 32'h0, 7'd0}},
      '{ACT_RSVD_7,    32'hFFFF_FFFF, 7'd127, 1'b1, '{1'b1, 32'h0, 7'd0}},
      '{ACT_APPEND,    32'hFFFF_FFFF, 7'd127, 1'b1, '{1'b0, 32'h0, 7'd1}},
      '{ACT_PUSH,      32'h0000_0000, 7'd0,   1'b1, '{1'b0, 32'h0, 7'd2}},
      '{ACT_INSERT,    32'hA5A5_A5A5, 7'd1,   1'b0, '0},
      '{ACT_INSERT,    32'h5A5A_5A5A, 7'd3,   1'b0, '0},
      '{ACT_INSERT,    32'h0000_0001, 7'd0,   1'b0, '0},
      '{ACT_INSERT,    32'hDEAD_BEEF, 7'd6,   1'b1, '{1'b1, 32'h0, 7'd5}},
      '{ACT_RSVD_5,    32'h0F0F_0F0F, 7'd2,   1'b0, '0},
      '{ACT_RSVD_6,    32'hF0F0_F0F0, 7'd0,   1'b0, '0},
      '{ACT_POP_BACK,  32'h0000_0000, 7'd0,   1'b0, '0},
      '{ACT_POP_FRONT, 32'h0000_0000, 7'd0,   1'b0, '0},
      '{ACT_POP_BACK,  32'h0000_0000, 7'd0,   1'b0, '0},
      '{ACT_POP_FRONT, 32'h0000_0000, 7'd0,   1'b0, '0},
      '{ACT_POP_FRONT, 32'h0000_0000, 7'd0,   1'b0, '0},
      '{ACT_POP_BACK,  32'h0000_0000, 7'd0,   1'b1, '{1'b1, 32'h0, 7'd0}},
      '{ACT_APPEND,    32'h8000_0000, 7'd0,   1'b0, '0},
      '{ACT_INSERT,    32'h7FFF_FFFF, 7'd1,   1'b0, '0},
      '{ACT_POP_BACK,  32'h0000_0000, 7'd0,   1'b0, '0}
   };

   bounded_list_with_positional_insert_top DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_item         (req_item),
      .req_position     (req_position),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_removed_item (rsp_removed_item),
      .rsp_length       (rsp_length)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic list_result_type list_apply(input logic [ACTION_W-1:0] act,
                                                  input logic [REQ_ITEM_W-1:0] word_in,
                                                  input logic [POSITION_W-1:0] pos);
      list_result_type res;
      int              slot;
      int              k;
      bit              ok;
      res.removed = '0;
      ok = 1'b0;
      slot = -1;
      case (act)
         ACT_APPEND: slot = shadow_len;
         ACT_PUSH:   slot = 0;
         ACT_INSERT: slot = int'(pos);
         ACT_POP_FRONT: begin
            if (shadow_len > 0) begin
               res.removed = shadow_cells[0];
               for (k = 0; k + 1 < shadow_len; k++) shadow_cells[k] = shadow_cells[k + 1];
               shadow_len--;
               ok = 1'b1;
            end
         end
         ACT_POP_BACK: begin
            if (shadow_len > 0) begin
               res.removed = shadow_cells[shadow_len - 1];
               shadow_len--;
               ok = 1'b1;
            end
         end
         default: ok = 1'b0;
      endcase
      if (slot >= 0 && shadow_len < LIST_DEPTH && slot <= shadow_len) begin
         for (k = shadow_len; k > slot; k--) shadow_cells[k] = shadow_cells[k - 1];
         shadow_cells[slot] = word_in;
         shadow_len++;
         ok = 1'b1;
      end
      res.status = !ok;
      res.length = shadow_len[LENGTH_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch on %s: got %h, want %h", $time, field, got, want);
      mismatch_count++;
   endtask

   // hold the word until busy is low at a rising edge, then queue its result
   task automatic send_word(input logic [ACTION_W-1:0] act,
                            input logic [REQ_ITEM_W-1:0] word_in,
                            input logic [POSITION_W-1:0] pos,
                            input logic typed,
                            input list_result_type typed_res,
                            input bit allow_idle);
      list_result_type res;
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(1, 7) - 1) @(negedge clock);
      end
      @(negedge clock);
      start        <= 1'b1;
      req_action   <= act;
      req_item     <= word_in;
      req_position <= pos;
      do @(posedge clock); while (busy);
      res = list_apply(act, word_in, pos);
      expected_results.push_back(typed ? typed_res : res);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected strobe", {31'd0, rsp_strobe}, 32'd0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", {31'd0, rsp_status}, {31'd0, want.status});
            if (rsp_removed_item !== want.removed)
               report_mismatch("removed_item", rsp_removed_item, want.removed);
            if (rsp_length !== want.length)
               report_mismatch("length", {25'd0, rsp_length}, {25'd0, want.length});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int                    n;
      int                    mode;
      int                    mode_left;
      int                    pick;
      int                    add_pct;
      logic [ACTION_W-1:0]   act;
      logic [REQ_ITEM_W-1:0] word_in;
      logic [POSITION_W-1:0] pos;

      shadow_len     = 0;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_action   <= ACT_APPEND;
      req_item     <= '0;
      req_position <= '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (n = 0; n < NUM_DIRECTED; n++)
         send_word(directed_rows[n].action, directed_rows[n].item,
                   directed_rows[n].position, directed_rows[n].typed,
                   directed_rows[n].result, 1'b1);
      wait_drained();

      mode = 0;
      mode_left = 0;
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         // grow, shrink or mixed phase
         add_pct = (mode == 0) ? 75 : (mode == 1) ? 20 : 50;
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            act = ACTION_W'($urandom_range(ACT_RSVD_5, ACT_RSVD_7));
         end else if (pick < 5 + add_pct) begin
            act = ACTION_W'($urandom_range(ACT_APPEND, ACT_INSERT));
         end else begin
            act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
         end
         case ($urandom_range(0, 9))
            0, 1:    word_in = $urandom_range(0, 1) ? '0 : '1;
            default: word_in = $urandom;
         endcase
         pick = $urandom_range(0, 9);
         if (pick < 6)       pos = POSITION_W'($urandom_range(0, shadow_len));
         else if (pick == 6) pos = POSITION_W'(shadow_len);
         else if (pick == 7) pos = '0;
         else                pos = POSITION_W'($urandom_range(0, 127));
         send_word(act, word_in, pos, 1'b0, '0, n < (RANDOM_WORDS * 4) / 5);
         if (n % 200 == 199) wait_drained();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
